// ===== sv/gohlc_pkg.sv =====
// gohlc_pkg: widths, limits, queue entry and control types for the candle aggregator
// no dependencies; imported by every module of the block
`default_nettype none

package gohlc_pkg;

   localparam int unsigned MAX_GROUP_SAMPLES = 65536;

   localparam int YEAR_W  = 16;
   localparam int TEMP_W  = 15;
   localparam int CNT_W   = $clog2(MAX_GROUP_SAMPLES + 1);
   localparam int SUM_W   = TEMP_W + CNT_W + 1;
   localparam int STEP_W  = $clog2(SUM_W + 1);

   // queue depth must be a power of two and at least two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [YEAR_W-1:0]        year;
      logic signed [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]         count;
      logic signed [TEMP_W-1:0] high;
      logic signed [TEMP_W-1:0] low;
      logic                     overflow;
      logic                     last;
      logic                     use_prev;
   } gohlc_job_type;

   typedef struct packed {
      logic          first_vld;
      logic          second_vld;
      gohlc_job_type first;
      gohlc_job_type second;
   } gohlc_push_type;

   typedef struct packed {
      logic not_empty;
      logic room;
   } gohlc_qstat_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_FINISH,
      BACK_SEND
   } gohlc_back_state_type;

endpackage

`default_nettype wire

// ===== sv/grouped_ohlc_candle_aggregator.sv =====
// grouped_ohlc_candle_aggregator: top level, front, candle queue and back end
// depends on gohlc_pkg, gohlc_front, gohlc_queue, gohlc_back
//
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   year_key, temperature, final_sample
// rsp_      out        rsp_valid/rsp_stall   candle_year, open, high, low, close,
//                                            count_overflow, last_of_run
//
// samples are taken one per cycle while the queue has room for two candles
// the back end takes one candle at a time: a pop, 33 steps of the bit-serial
// sum/count divider, a finish state that forms the candle, then a send state until taken
// a sample that closes a group costs nothing extra up front; the divider sets candle rate
// synchronous reset clears control state only; no clearing pass is needed
// rsp_stall holds the candle in the output register; req_stall rises when fewer than
// two queue entries are free
`default_nettype none

module grouped_ohlc_candle_aggregator import gohlc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [YEAR_W-1:0]        req_year_key,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     req_final_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [YEAR_W-1:0]        rsp_candle_year,
   output logic signed [TEMP_W-1:0] rsp_open_value,
   output logic signed [TEMP_W-1:0] rsp_high_value,
   output logic signed [TEMP_W-1:0] rsp_low_value,
   output logic signed [TEMP_W-1:0] rsp_close_value,
   output logic                     rsp_count_overflow,
   output logic                     rsp_last_of_run
);

   gohlc_push_type  push;
   gohlc_qstat_type qstat;
   gohlc_job_type   head;
   logic            pop;

   gohlc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_year_key     (req_year_key),
      .req_temperature  (req_temperature),
      .req_final_sample (req_final_sample),
      .qstat            (qstat),
      .push             (push)
   );

   gohlc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   gohlc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_candle_year    (rsp_candle_year),
      .rsp_open_value     (rsp_open_value),
      .rsp_high_value     (rsp_high_value),
      .rsp_low_value      (rsp_low_value),
      .rsp_close_value    (rsp_close_value),
      .rsp_count_overflow (rsp_count_overflow),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== sv/gohlc_front.sv =====
// gohlc_front: takes samples, keeps the running group and queues finished candles
// depends on gohlc_pkg
`default_nettype none

module gohlc_front import gohlc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [YEAR_W-1:0]        req_year_key,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     req_final_sample,
   input  gohlc_qstat_type          qstat,
   output gohlc_push_type           push
);

   logic                     open_ff, open_in;
   logic                     have_prev_ff, have_prev_in;
   logic [YEAR_W-1:0]        year_ff, year_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [TEMP_W-1:0] high_ff, high_in;
   logic signed [TEMP_W-1:0] low_ff, low_in;
   logic                     ovf_ff, ovf_in;

   logic                    accept;
   logic                    key_change;
   logic                    start;
   logic                    full;
   logic signed [SUM_W-1:0] temp_ext;
   gohlc_job_type           old_job;
   gohlc_job_type           fin_job;

   always_comb begin
      accept     = req_valid && qstat.room;
      req_stall  = !qstat.room;
      key_change = open_ff && (req_year_key != year_ff);
      start      = !open_ff || key_change;
      full       = count_ff >= CNT_W'(MAX_GROUP_SAMPLES);
      temp_ext   = {{(SUM_W - TEMP_W){req_temperature[TEMP_W-1]}}, req_temperature};

      year_in  = year_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      ovf_in   = ovf_ff;
      if (start) begin
         year_in  = req_year_key;
         sum_in   = temp_ext;
         count_in = CNT_W'(1);
         high_in  = req_temperature;
         low_in   = req_temperature;
         ovf_in   = 1'b0;
      end else begin
         if (req_temperature > high_ff) begin
            high_in = req_temperature;
         end
         if (req_temperature < low_ff) begin
            low_in = req_temperature;
         end
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            sum_in   = sum_ff + temp_ext;
            count_in = count_ff + CNT_W'(1);
         end
      end

      old_job.year     = year_ff;
      old_job.sum      = sum_ff;
      old_job.count    = count_ff;
      old_job.high     = high_ff;
      old_job.low      = low_ff;
      old_job.overflow = ovf_ff;
      old_job.last     = !req_final_sample;
      old_job.use_prev = have_prev_ff;

      fin_job.year     = year_in;
      fin_job.sum      = sum_in;
      fin_job.count    = count_in;
      fin_job.high     = high_in;
      fin_job.low      = low_in;
      fin_job.overflow = ovf_in;
      fin_job.last     = 1'b1;
      fin_job.use_prev = have_prev_ff || key_change;

      push.first_vld  = accept && (key_change || req_final_sample);
      push.second_vld = accept && key_change && req_final_sample;
      push.first      = key_change ? old_job : fin_job;
      push.second     = fin_job;

      open_in      = !req_final_sample;
      have_prev_in = req_final_sample ? 1'b0 : (key_change ? 1'b1 : have_prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
      end else if (accept) begin
         open_ff      <= open_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         year_ff  <= year_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/gohlc_queue.sv =====
// gohlc_queue: small candle queue, up to two writes and one read per cycle
// depends on gohlc_pkg
`default_nettype none

module gohlc_queue import gohlc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  gohlc_push_type  push,
   input  logic            pop,
   output gohlc_job_type   head,
   output gohlc_qstat_type qstat
);

   gohlc_job_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wp_ff, wp_in;
   logic [QPTR_W-1:0]  rp_ff, rp_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic [QPTR_W-1:0]  wp_next;

   always_comb begin
      wp_next = wp_ff + QPTR_W'(1);
      wp_in   = wp_ff + QPTR_W'(push.first_vld) + QPTR_W'(push.second_vld);
      rp_in   = rp_ff + QPTR_W'(pop);
      fill_in = fill_ff + QFILL_W'(push.first_vld) + QFILL_W'(push.second_vld)
                - QFILL_W'(pop);
      head            = mem_ff[rp_ff];
      qstat.not_empty = fill_ff != '0;
      qstat.room      = fill_ff <= QFILL_W'(QUEUE_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (push.second_vld) begin
         mem_ff[wp_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ===== sv/gohlc_back.sv =====
// gohlc_back: takes queued groups, divides sum by count bit-serially, forms the candle
// depends on gohlc_pkg
`default_nettype none

module gohlc_back import gohlc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  gohlc_job_type            head,
   input  gohlc_qstat_type          qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [YEAR_W-1:0]        rsp_candle_year,
   output logic signed [TEMP_W-1:0] rsp_open_value,
   output logic signed [TEMP_W-1:0] rsp_high_value,
   output logic signed [TEMP_W-1:0] rsp_low_value,
   output logic signed [TEMP_W-1:0] rsp_close_value,
   output logic                     rsp_count_overflow,
   output logic                     rsp_last_of_run
);

   gohlc_back_state_type state_ff, state_in;

   gohlc_job_type            job_ff;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]         qr_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     neg_ff;
   logic signed [TEMP_W-1:0] prev_close_ff;

   logic                     valid_ff;
   logic [YEAR_W-1:0]        year_ff;
   logic signed [TEMP_W-1:0] open_ff;
   logic signed [TEMP_W-1:0] high_ff;
   logic signed [TEMP_W-1:0] low_ff;
   logic signed [TEMP_W-1:0] close_ff;
   logic                     ovf_ff;
   logic                     last_ff;

   logic                     load;
   logic                     finish;
   logic                     send_done;
   logic [SUM_W-1:0]         head_mag;
   logic [CNT_W:0]           trial;
   logic [CNT_W:0]           diff;
   logic                     ge;
   logic [SUM_W-1:0]         quot;
   logic signed [TEMP_W-1:0] close_in;
   logic signed [TEMP_W:0]   hl_sum;
   logic signed [TEMP_W-1:0] open_in;

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      load      = 1'b0;
      finish    = 1'b0;
      send_done = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (qstat.not_empty) begin
               pop      = 1'b1;
               load     = 1'b1;
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            finish   = 1'b1;
            state_in = BACK_SEND;
         end
         BACK_SEND: begin
            if (!rsp_stall) begin
               send_done = 1'b1;
               state_in  = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      head_mag = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);
      trial    = {rem_ff, qr_ff[SUM_W-1]};
      diff     = trial - {1'b0, job_ff.count};
      ge       = trial >= {1'b0, job_ff.count};
      rem_in   = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quot     = neg_ff ? SUM_W'(-qr_ff) : qr_ff;
      close_in = quot[TEMP_W-1:0];
      hl_sum   = (TEMP_W+1)'(job_ff.high) + (TEMP_W+1)'(job_ff.low);
      open_in  = job_ff.use_prev ? prev_close_ff : hl_sum[TEMP_W:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            valid_ff <= 1'b1;
         end else if (send_done) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff  <= head;
         qr_ff   <= head_mag;
         rem_ff  <= '0;
         step_ff <= '0;
         neg_ff  <= head.sum[SUM_W-1];
      end else if (state_ff == BACK_DIVIDE) begin
         qr_ff   <= {qr_ff[SUM_W-2:0], ge};
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (finish) begin
         year_ff       <= job_ff.year;
         open_ff       <= open_in;
         high_ff       <= job_ff.high;
         low_ff        <= job_ff.low;
         close_ff      <= close_in;
         ovf_ff        <= job_ff.overflow;
         last_ff       <= job_ff.last;
         prev_close_ff <= close_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_candle_year    = year_ff;
   assign rsp_open_value     = open_ff;
   assign rsp_high_value     = high_ff;
   assign rsp_low_value      = low_ff;
   assign rsp_close_value    = close_ff;
   assign rsp_count_overflow = ovf_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

`default_nettype wire

// ===== sv/gohlc_checker.sv =====
// gohlc_checker: port-level assertions for the candle aggregator, bound to the top level
// depends on gohlc_pkg and grouped_ohlc_candle_aggregator
`default_nettype none

module gohlc_checker import gohlc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [YEAR_W-1:0]        req_year_key,
   input logic signed [TEMP_W-1:0] req_temperature,
   input logic                     req_final_sample,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [YEAR_W-1:0]        rsp_candle_year,
   input logic signed [TEMP_W-1:0] rsp_open_value,
   input logic signed [TEMP_W-1:0] rsp_high_value,
   input logic signed [TEMP_W-1:0] rsp_low_value,
   input logic signed [TEMP_W-1:0] rsp_close_value,
   input logic                     rsp_count_overflow,
   input logic                     rsp_last_of_run
);

   // nothing pending and ready for a transaction right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   // a candle's range is never inverted
   a_high_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_high_value >= rsp_low_value)
      else $error("candle high below low");

   // the mean lies within the group's range
   a_close_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_close_value >= rsp_low_value && rsp_close_value <= rsp_high_value)
      else $error("candle close outside high and low");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_candle_year)
                                 && $stable(rsp_close_value))
      else $error("stalled candle transaction changed");

endmodule

bind grouped_ohlc_candle_aggregator gohlc_checker u_gohlc_checker (.*);

`default_nettype wire
